>>> hdl/blur3_pkg.sv
// ----------------------------------------------------------------------------
// blur3_pkg
// Types, register codes and arithmetic shared by the 3x3 rgb blur modules.
// ----------------------------------------------------------------------------
package blur3_pkg;

  localparam int unsigned CH_W       = 8;
  localparam int unsigned HF_W       = 12;
  localparam int unsigned ROW_W      = 12;
  localparam int unsigned OUT_COL_W  = 12;
  localparam int unsigned WT_W       = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned ZOOM_W     = 10;

  localparam int unsigned MAX_HEIGHT    = 4096;
  localparam int unsigned RESET_WIDTH   = 4096;
  localparam logic [ZOOM_W-1:0] ZOOM_RESET = 10'd100;

  // zoom thresholds, inclusive upper bounds for each edge weight
  localparam logic [ZOOM_W-1:0] ZOOM_W4_MAX = 10'd120;
  localparam logic [ZOOM_W-1:0] ZOOM_W3_MAX = 10'd135;
  localparam logic [ZOOM_W-1:0] ZOOM_W2_MAX = 10'd150;
  localparam logic [ZOOM_W-1:0] ZOOM_W1_MAX = 10'd170;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_ZOOM_PERCENT = 2'd2
  } cfg_reg_t;

  // red in the low bits, matching the stream data layout
  typedef struct packed {
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
  } pixel_t;

  // horizontally filtered pixel, 12 bits per channel
  typedef struct packed {
    logic [HF_W-1:0] blue;
    logic [HF_W-1:0] green;
    logic [HF_W-1:0] red;
  } hpix_t;

  // one line store entry: the two most recent filtered rows of a column
  typedef struct packed {
    hpix_t older;
    hpix_t newer;
  } line_t;

  // one column update handed to the vertical stage
  typedef struct packed {
    logic [ROW_W-1:0] row;
    hpix_t            h;
    logic             last;
  } job_t;

  typedef struct packed {
    logic [ROW_W-1:0]     row;
    logic [OUT_COL_W-1:0] col;
    pixel_t               pix;
    logic                 last;
  } res_t;

  function automatic logic [WT_W-1:0] edge_weight(input logic [ZOOM_W-1:0] zoom);
    logic [WT_W-1:0] w;
    priority if (zoom <= ZOOM_W4_MAX) w = 3'd4;
    else if (zoom <= ZOOM_W3_MAX)     w = 3'd3;
    else if (zoom <= ZOOM_W2_MAX)     w = 3'd2;
    else if (zoom <= ZOOM_W1_MAX)     w = 3'd1;
    else                              w = 3'd0;
    return w;
  endfunction

  function automatic logic [HF_W-1:0] hchan(input logic [CH_W-1:0] l,
                                            input logic [CH_W-1:0] c,
                                            input logic [CH_W-1:0] r,
                                            input logic [WT_W-1:0] w);
    logic [4:0]  k;
    logic [8:0]  lr;
    logic [12:0] s;
    k  = 5'd16 - {1'b0, w, 1'b0};
    lr = {1'b0, l} + {1'b0, r};
    s  = ({4'b0, lr} * {10'b0, w}) + ({5'b0, c} * {8'b0, k});
    return s[HF_W-1:0];
  endfunction

  function automatic hpix_t hsum(input pixel_t l, input pixel_t c, input pixel_t r,
                                 input logic [WT_W-1:0] w);
    hpix_t h;
    h.red   = hchan(l.red,   c.red,   r.red,   w);
    h.green = hchan(l.green, c.green, r.green, w);
    h.blue  = hchan(l.blue,  c.blue,  r.blue,  w);
    return h;
  endfunction

  function automatic logic [CH_W-1:0] vchan(input logic [HF_W-1:0] p,
                                            input logic [HF_W-1:0] c,
                                            input logic [HF_W-1:0] n,
                                            input logic [WT_W-1:0] w);
    logic [4:0]  k;
    logic [12:0] pn;
    logic [16:0] s;
    k  = 5'd16 - {1'b0, w, 1'b0};
    pn = {1'b0, p} + {1'b0, n};
    s  = ({4'b0, pn} * {14'b0, w}) + ({5'b0, c} * {12'b0, k});
    return s[15:8];
  endfunction

  function automatic pixel_t vsum(input hpix_t p, input hpix_t c, input hpix_t n,
                                  input logic [WT_W-1:0] w);
    pixel_t o;
    o.red   = vchan(p.red,   c.red,   n.red,   w);
    o.green = vchan(p.green, c.green, n.green, w);
    o.blue  = vchan(p.blue,  c.blue,  n.blue,  w);
    return o;
  endfunction

endpackage

>>> hdl/blur3_vfilt.sv
// ----------------------------------------------------------------------------
// blur3_vfilt
// Vertical stage: line store read-modify-write per column and output register.
// ----------------------------------------------------------------------------
module blur3_vfilt #(
  parameter int unsigned MAX_WIDTH = 4096
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [blur3_pkg::ROW_W-1:0]         hgt_last,
  input  logic [blur3_pkg::WT_W-1:0]          edge_w,
  input  logic                                job_valid,
  output logic                                job_ready,
  input  logic [$clog2(MAX_WIDTH)-1:0]        job_col,
  input  blur3_pkg::job_t                     job,
  output logic                                res_valid,
  input  logic                                res_ready,
  output blur3_pkg::res_t                     res
);

  localparam int unsigned COL_W = $clog2(MAX_WIDTH);

  blur3_pkg::line_t mem [MAX_WIDTH];

  logic                        b_valid;
  logic [COL_W-1:0]            b_col;
  blur3_pkg::job_t             b_job;
  logic                        b_sub;
  blur3_pkg::line_t            rd_q;
  logic                        fwd_hit;
  blur3_pkg::line_t            fwd_q;
  blur3_pkg::res_t             res_q;
  logic                        res_v;

  blur3_pkg::line_t            cur_line;
  blur3_pkg::line_t            wr_line;
  blur3_pkg::hpix_t            tp, tc, tn;
  logic                        first_row, last_row, has_res, has_two, at_end;
  logic                        out_free, push, b_done, b_load;
  blur3_pkg::res_t             res_next;

  always_comb begin
    // entry written on the same edge as the read comes from the bypass
    cur_line  = fwd_hit ? fwd_q : rd_q;
    first_row = (b_job.row == '0);
    last_row  = (b_job.row == hgt_last);
    has_res   = !first_row || (hgt_last == '0);
    has_two   = !first_row && last_row;
    at_end    = !has_two || b_sub;
    out_free  = !res_v || res_ready;
    push      = b_valid && has_res && out_free;
    b_done    = b_valid && (!has_res || (out_free && at_end));
    job_ready = !b_valid || b_done;
    b_load    = job_valid && job_ready;

    if (first_row) begin
      wr_line.older = b_job.h;
    end else begin
      wr_line.older = cur_line.newer;
    end
    wr_line.newer = b_job.h;

    if (b_sub) begin
      tp = cur_line.newer;
      tc = b_job.h;
      tn = b_job.h;
    end else if (first_row) begin
      tp = b_job.h;
      tc = b_job.h;
      tn = b_job.h;
    end else begin
      tp = cur_line.older;
      tc = cur_line.newer;
      tn = b_job.h;
    end

    res_next.pix  = blur3_pkg::vsum(tp, tc, tn, edge_w);
    res_next.col  = blur3_pkg::OUT_COL_W'(b_col);
    res_next.row  = (b_sub || first_row) ? b_job.row : b_job.row - 1'b1;
    res_next.last = b_job.last && at_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      b_sub   <= 1'b0;
      res_v   <= 1'b0;
    end else begin
      if (b_load) begin
        b_valid <= 1'b1;
      end else if (b_done) begin
        b_valid <= 1'b0;
      end
      if (b_done) begin
        b_sub <= 1'b0;
      end else if (push) begin
        b_sub <= 1'b1;
      end
      if (push) begin
        res_v <= 1'b1;
      end else if (res_ready) begin
        res_v <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (b_load) begin
      b_col   <= job_col;
      b_job   <= job;
      fwd_hit <= b_done && (b_col == job_col);
      fwd_q   <= wr_line;
    end
    if (push) begin
      res_q <= res_next;
    end
  end

  // line store, one read and one write port
  always_ff @(posedge clk) begin
    if (b_load) begin
      rd_q <= mem[job_col];
    end
  end

  always_ff @(posedge clk) begin
    if (b_done) begin
      mem[b_col] <= wr_line;
    end
  end

  assign res_valid = res_v;
  assign res       = res_q;

endmodule

>>> hdl/separable_3x3_rgb_blur.sv
// ----------------------------------------------------------------------------
// separable_3x3_rgb_blur
// Streaming separable 3x3 blur on rgb888 pixels with replicated borders.
// ----------------------------------------------------------------------------
//  channel   direction  beat contents
//  s_axis    in         one pixel in raster order
//  m_axis    out        one blurred pixel with its column and row, tlast
//  cfg       in         register index and write data, always ready
//
//  one pixel per cycle, unless m_axis stalls or a pixel gives more than one update
//  or beat; a row-end pixel in a row of two or more columns makes two column
//  updates, one at a time through the vertical stage. on the last row of a frame
//  of two or more rows each column update gives two beats. m_axis_tvalid rises
//  after the column update, vertical stage job and output registers. reset clears
//  counters, valids, neighbor pixels and config; the line store needs no clearing.
// ----------------------------------------------------------------------------
module separable_3x3_rgb_blur #(
  parameter int unsigned MAX_WIDTH = 4096
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [23:0]                       s_axis_tdata,  // red, green, blue
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [47:0]                       m_axis_tdata,  // out_red, out_green,
                                                           // out_blue, out_col, out_row
  output logic                              m_axis_tlast,  // last_of_run
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [blur3_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [blur3_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int unsigned COL_W  = $clog2(MAX_WIDTH);
  localparam int unsigned RST_WD = (MAX_WIDTH < blur3_pkg::RESET_WIDTH) ?
                                   MAX_WIDTH : blur3_pkg::RESET_WIDTH;

  // configuration, held as last column / last row
  logic [COL_W-1:0]                 wd_last;
  logic [blur3_pkg::ROW_W-1:0]      hgt_last;
  logic [blur3_pkg::WT_W-1:0]       edge_w;

  // row context
  logic [COL_W-1:0]                 col_cnt;
  logic [blur3_pkg::ROW_W-1:0]      row_cnt;
  blur3_pkg::pixel_t                left_px, center_px;

  // column update stage
  logic                             a_pend0, a_pend1;
  logic [COL_W-1:0]                 a_x;
  logic [blur3_pkg::ROW_W-1:0]      a_y;
  blur3_pkg::pixel_t                a_l0, a_c, a_cur, a_l1;

  logic [COL_W-1:0]                 x;
  logic [blur3_pkg::ROW_W-1:0]      y;
  logic                             row_end, frame_end;
  blur3_pkg::pixel_t                cur;
  logic                             in_fire;

  logic                             job_valid, job_ready, job_fire;
  logic [COL_W-1:0]                 job_col;
  blur3_pkg::job_t                  job;
  blur3_pkg::pixel_t                sel_l, sel_c;

  logic                             res_valid;
  blur3_pkg::res_t                  res;

  always_comb begin
    x         = (col_cnt > wd_last) ? wd_last : col_cnt;
    y         = (row_cnt > hgt_last) ? hgt_last : row_cnt;
    row_end   = (x == wd_last);
    frame_end = (y == hgt_last);
    cur       = blur3_pkg::pixel_t'(s_axis_tdata);

    job_valid = a_pend0 || a_pend1;
    sel_l     = a_pend0 ? a_l0 : a_l1;
    sel_c     = a_pend0 ? a_c  : a_cur;
    job_col   = a_pend0 ? a_x - 1'b1 : a_x;
    job.row   = a_y;
    job.h     = blur3_pkg::hsum(sel_l, sel_c, a_cur, edge_w);
    job.last  = !(a_pend0 && a_pend1);
    job_fire  = job_valid && job_ready;

    s_axis_tready = !job_valid || (job_fire && job.last);
    in_fire       = s_axis_tvalid && s_axis_tready;
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      wd_last  <= COL_W'(RST_WD - 1);
      hgt_last <= blur3_pkg::ROW_W'(blur3_pkg::MAX_HEIGHT - 1);
      edge_w   <= blur3_pkg::edge_weight(blur3_pkg::ZOOM_RESET);
    end else if (cfg_valid && cfg_ready) begin
      unique case (blur3_pkg::cfg_reg_t'(cfg_index))
        blur3_pkg::REG_IMAGE_WIDTH: begin
          if (cfg_data == '0) begin
            wd_last <= '0;
          end else if (32'(cfg_data) > MAX_WIDTH) begin
            wd_last <= COL_W'(MAX_WIDTH - 1);
          end else begin
            wd_last <= COL_W'(cfg_data - 1'b1);
          end
        end
        blur3_pkg::REG_IMAGE_HEIGHT: begin
          if (cfg_data == '0) begin
            hgt_last <= '0;
          end else if (32'(cfg_data) > blur3_pkg::MAX_HEIGHT) begin
            hgt_last <= blur3_pkg::ROW_W'(blur3_pkg::MAX_HEIGHT - 1);
          end else begin
            hgt_last <= blur3_pkg::ROW_W'(cfg_data - 1'b1);
          end
        end
        blur3_pkg::REG_ZOOM_PERCENT: begin
          edge_w <= blur3_pkg::edge_weight(cfg_data[blur3_pkg::ZOOM_W-1:0]);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt   <= '0;
      row_cnt   <= '0;
      left_px   <= '0;
      center_px <= '0;
      a_pend0   <= 1'b0;
      a_pend1   <= 1'b0;
    end else begin
      if (in_fire) begin
        left_px   <= center_px;
        center_px <= cur;
        if (row_end) begin
          col_cnt <= '0;
          row_cnt <= frame_end ? '0 : y + 1'b1;
        end else begin
          col_cnt <= x + 1'b1;
          row_cnt <= y;
        end
        // left neighbor column needs x > 0, own column only at row end
        a_pend0 <= (x != '0);
        a_pend1 <= row_end;
      end else if (job_fire) begin
        if (a_pend0) begin
          a_pend0 <= 1'b0;
        end else begin
          a_pend1 <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_x   <= x;
      a_y   <= y;
      a_c   <= center_px;
      a_cur <= cur;
      a_l0  <= (x == COL_W'(1)) ? center_px : left_px;
      a_l1  <= (x == '0) ? cur : center_px;
    end
  end

  blur3_vfilt #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_vfilt (
    .clk       (clk),
    .rst       (rst),
    .hgt_last  (hgt_last),
    .edge_w    (edge_w),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job_col   (job_col),
    .job       (job),
    .res_valid (res_valid),
    .res_ready (m_axis_tready),
    .res       (res)
  );

  assign m_axis_tvalid = res_valid;
  assign m_axis_tdata  = {res.row, res.col, res.pix};
  assign m_axis_tlast  = res.last;

endmodule

>>> hdl/blur3_chk.sv
// ----------------------------------------------------------------------------
// blur3_chk
// Port-level checks for the 3x3 rgb blur, bound to the top level.
// ----------------------------------------------------------------------------
module blur3_chk (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic        m_axis_tlast,
  input logic        cfg_ready
);

  // a stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output beat changed while stalled");

  // reset empties the pipeline and opens the input
  a_rst_clear: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid && s_axis_tready)
    else $error("pipeline not empty after reset");

  // config port never backpressures
  a_cfg_open: assert property (@(posedge clk) disable iff (rst)
    cfg_ready)
    else $error("config port not ready");

endmodule

bind separable_3x3_rgb_blur blur3_chk u_blur3_chk (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .cfg_ready     (cfg_ready)
);

>>> bench/separable_3x3_rgb_blur_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// separable_3x3_rgb_blur_tb
// Streams raster pixels through the blur and checks each output beat against a
// local line-store model: tiny directed frames for the border, size and zoom
// corner cases, one long output hold-off, then random frames and sizes.
// ----------------------------------------------------------------------------
module separable_3x3_rgb_blur_tb;

  localparam int STORE_DEPTH   = 4096;
  localparam int HEIGHT_CAP    = 4096;
  localparam int SETTLE_CYCLES = 24;
  localparam int HOLD_CYCLES   = 400;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int TARGET_PIXELS = 430;

  // horizontally filtered pixel as kept in the line stores
  typedef struct packed {
    logic [11:0] blue;
    logic [11:0] green;
    logic [11:0] red;
  } hsum_t;

  typedef struct {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [11:0] col;
    logic [11:0] row;
    logic        last;
  } blur_beat_t;

  logic                             clk           = 1'b0;
  logic                             rst           = 1'b1;
  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  logic [23:0]                      s_axis_tdata  = '0;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  logic [47:0]                      m_axis_tdata;
  logic                             m_axis_tlast;
  logic                             cfg_valid     = 1'b0;
  logic                             cfg_ready;
  blur3_pkg::cfg_reg_t              cfg_index     = blur3_pkg::REG_IMAGE_WIDTH;
  logic [blur3_pkg::CFG_DATA_W-1:0] cfg_data      = '0;

  // blur model state
  hsum_t              older_rows [STORE_DEPTH];
  hsum_t              newer_rows [STORE_DEPTH];
  blur3_pkg::pixel_t  left_px    = '0;
  blur3_pkg::pixel_t  center_px  = '0;
  int                 col_pos    = 0;
  int                 row_pos    = 0;
  logic [12:0]        width_reg  = 13'd4096;
  logic [12:0]        height_reg = 13'd4096;
  logic [9:0]         zoom_reg   = blur3_pkg::ZOOM_RESET;

  blur_beat_t   expected_beats [$];
  logic [23:0]  pixel_q [$];

  bit           tx_gaps_on     = 1'b0;
  bit           rx_stalls_on   = 1'b0;
  int           tx_gap_left    = 0;
  int           rx_stall_left  = 0;
  int           hold_requests  = 0;
  int           holds_served   = 0;
  int           hold_left      = 0;
  int           cycle_count    = 0;
  int           pixels_sent    = 0;
  int           beats_seen     = 0;
  int           mismatch_count = 0;
  int           cfg_writes     = 0;

  separable_3x3_rgb_blur DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int clamp_width(logic [12:0] v);
    if (v == 0) return 1;
    if (v > STORE_DEPTH) return STORE_DEPTH;
    return int'(v);
  endfunction

  function automatic int frame_width();
    return clamp_width(width_reg);
  endfunction

  function automatic int frame_height();
    if (height_reg == 0) return 1;
    if (height_reg > HEIGHT_CAP) return HEIGHT_CAP;
    return int'(height_reg);
  endfunction

  function automatic int cur_row();
    return (row_pos >= frame_height()) ? frame_height() - 1 : row_pos;
  endfunction

  function automatic int blur_strength();
    if (zoom_reg <= blur3_pkg::ZOOM_W4_MAX) return 4;
    if (zoom_reg <= blur3_pkg::ZOOM_W3_MAX) return 3;
    if (zoom_reg <= blur3_pkg::ZOOM_W2_MAX) return 2;
    if (zoom_reg <= blur3_pkg::ZOOM_W1_MAX) return 1;
    return 0;
  endfunction

  function automatic logic [11:0] hmix(logic [7:0] l, logic [7:0] c, logic [7:0] r, int w);
    return 12'(int'(l) * w + int'(c) * (16 - 2 * w) + int'(r) * w);
  endfunction

  function automatic hsum_t hfilt(blur3_pkg::pixel_t l, blur3_pkg::pixel_t c,
                                  blur3_pkg::pixel_t r, int w);
    hsum_t h;
    h.red   = hmix(l.red, c.red, r.red, w);
    h.green = hmix(l.green, c.green, r.green, w);
    h.blue  = hmix(l.blue, c.blue, r.blue, w);
    return h;
  endfunction

  function automatic logic [7:0] vmix(logic [11:0] p, logic [11:0] c, logic [11:0] n, int w);
    int s;
    s = int'(p) * w + int'(c) * (16 - 2 * w) + int'(n) * w;
    return 8'(s >> 8);
  endfunction

  function automatic void expect_beat(hsum_t p, hsum_t c, hsum_t n, int w, int col, int row);
    blur_beat_t b;
    b.red   = vmix(p.red, c.red, n.red, w);
    b.green = vmix(p.green, c.green, n.green, w);
    b.blue  = vmix(p.blue, c.blue, n.blue, w);
    b.col   = 12'(col);
    b.row   = 12'(row);
    b.last  = 1'b0;
    expected_beats.push_back(b);
  endfunction

  // one finished column: vertical pass over the two stored rows, then rotate
  function automatic void column_update(int col, int y, int hgt, int w, hsum_t h);
    if (y == 0) begin
      if (hgt == 1) expect_beat(h, h, h, w, col, 0);
      older_rows[col] = h;
      newer_rows[col] = h;
    end else begin
      expect_beat(older_rows[col], newer_rows[col], h, w, col, y - 1);
      // last row flushes itself, bottom border replicated
      if (y == hgt - 1) expect_beat(newer_rows[col], h, h, w, col, y);
      older_rows[col] = newer_rows[col];
      newer_rows[col] = h;
    end
  endfunction

  function automatic void blur_pixel(blur3_pkg::pixel_t cur);
    int         wd;
    int         hgt;
    int         x;
    int         y;
    int         w;
    int         queued;
    blur_beat_t tail;
    wd  = frame_width();
    hgt = frame_height();
    x   = (col_pos >= wd) ? wd - 1 : col_pos;
    y   = (row_pos >= hgt) ? hgt - 1 : row_pos;
    w   = blur_strength();
    queued = expected_beats.size();
    if (x >= 1)
      column_update(x - 1, y, hgt, w, hfilt((x == 1) ? center_px : left_px, center_px, cur, w));
    if (x == wd - 1)
      column_update(x, y, hgt, w, hfilt((x == 0) ? cur : center_px, cur, cur, w));
    left_px   = center_px;
    center_px = cur;
    if (x == wd - 1) begin
      col_pos = 0;
      row_pos = (y == hgt - 1) ? 0 : y + 1;
    end else begin
      col_pos = x + 1;
      row_pos = y;
    end
    if (expected_beats.size() > queued) begin
      tail = expected_beats.pop_back();
      tail.last = 1'b1;
      expected_beats.push_back(tail);
    end
  endfunction

  function automatic int frame_pixels_left();
    int wd;
    int hgt;
    int x;
    int y;
    wd  = frame_width();
    hgt = frame_height();
    x   = (col_pos >= wd) ? wd - 1 : col_pos;
    y   = (row_pos >= hgt) ? hgt - 1 : row_pos;
    return (hgt - 1 - y) * wd + (wd - x);
  endfunction

  // mostly no pause, some short ones, a few long
  function automatic int pause_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [23:0] any_pixel();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return 24'h000000;
    if (roll == 1) return 24'hFFFFFF;
    return 24'($urandom());
  endfunction

  function automatic logic [blur3_pkg::CFG_DATA_W-1:0] pick_width();
    int roll;
    roll = $urandom_range(0, 19);
    if (roll == 0) return 13'd0;
    if (roll == 1) return 13'd8191;
    return 13'($urandom_range(1, 12));
  endfunction

  function automatic logic [blur3_pkg::CFG_DATA_W-1:0] pick_height();
    int roll;
    roll = $urandom_range(0, 19);
    if (roll == 0) return 13'd0;
    if (roll == 1) return 13'd8191;
    return 13'($urandom_range(1, 6));
  endfunction

  function automatic logic [blur3_pkg::CFG_DATA_W-1:0] pick_zoom();
    case ($urandom_range(0, 14))
      0:       return 13'd0;
      1:       return 13'd120;
      2:       return 13'd121;
      3:       return 13'd135;
      4:       return 13'd136;
      5:       return 13'd150;
      6:       return 13'd151;
      7:       return 13'd170;
      8:       return 13'd171;
      9:       return 13'd1023;
      default: return 13'($urandom_range(0, 1023));
    endcase
  endfunction

  // pixel source
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      tx_gap_left   <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        blur_pixel(blur3_pkg::pixel_t'(s_axis_tdata));
        pixels_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (tx_gap_left != 0) begin
          tx_gap_left   <= tx_gap_left - 1;
          s_axis_tvalid <= 1'b0;
        end else if (pixel_q.size() != 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= pixel_q.pop_front();
          tx_gap_left   <= tx_gaps_on ? pause_len() : 0;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // long output hold-off, counted on its own
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (holds_served != hold_requests) begin
      holds_served <= holds_served + 1;
      hold_left    <= HOLD_CYCLES;
    end
  end

  // result sink and checker
  always @(posedge clk) begin : rx_side
    blur_beat_t want;
    int         stall;
    if (rst) begin
      m_axis_tready <= 1'b0;
      rx_stall_left <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        beats_seen++;
        if (expected_beats.size() == 0) begin
          mismatch_count++;
          $display("%0t: expected no beat", $time);
          $display("%0t:   actual col %0d row %0d rgb %02x %02x %02x last %0b",
                   $time, m_axis_tdata[35:24], m_axis_tdata[47:36], m_axis_tdata[7:0],
                   m_axis_tdata[15:8], m_axis_tdata[23:16], m_axis_tlast);
        end else begin
          want = expected_beats.pop_front();
          if (m_axis_tdata[7:0] !== want.red || m_axis_tdata[15:8] !== want.green ||
              m_axis_tdata[23:16] !== want.blue || m_axis_tdata[35:24] !== want.col ||
              m_axis_tdata[47:36] !== want.row || m_axis_tlast !== want.last) begin
            mismatch_count++;
            $display("%0t: expected col %0d row %0d rgb %02x %02x %02x last %0b",
                     $time, want.col, want.row, want.red, want.green, want.blue, want.last);
            $display("%0t:   actual col %0d row %0d rgb %02x %02x %02x last %0b",
                     $time, m_axis_tdata[35:24], m_axis_tdata[47:36], m_axis_tdata[7:0],
                     m_axis_tdata[15:8], m_axis_tdata[23:16], m_axis_tlast);
          end
        end
      end
      if (hold_left != 0) begin
        m_axis_tready <= 1'b0;
      end else if (rx_stall_left != 0) begin
        rx_stall_left <= rx_stall_left - 1;
        m_axis_tready <= 1'b0;
      end else begin
        stall = rx_stalls_on ? pause_len() : 0;
        if (stall != 0) begin
          rx_stall_left <= stall - 1;
          m_axis_tready <= 1'b0;
        end else begin
          m_axis_tready <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic write_reg(blur3_pkg::cfg_reg_t idx, logic [blur3_pkg::CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cfg_writes++;
    case (idx)
      blur3_pkg::REG_IMAGE_WIDTH:  width_reg  = value;
      blur3_pkg::REG_IMAGE_HEIGHT: height_reg = value;
      blur3_pkg::REG_ZOOM_PERCENT: zoom_reg   = value[blur3_pkg::ZOOM_W-1:0];
      default: ;
    endcase
  endtask

  // block idle: nothing queued or in flight, every result back, pipeline settled
  task automatic wait_drained();
    @(negedge clk);
    while (pixel_q.size() != 0 || s_axis_tvalid || expected_beats.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic send_pixels(int count);
    @(negedge clk);
    repeat (count) pixel_q.push_back(any_pixel());
  endtask

  initial begin
    int                               k;
    int                               count;
    int                               random_pixels;
    logic [blur3_pkg::CFG_DATA_W-1:0] new_w;
    random_pixels = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // 3x3 frame, strongest blur, full-scale checkerboard
    write_reg(blur3_pkg::REG_IMAGE_WIDTH, 13'd3);
    write_reg(blur3_pkg::REG_IMAGE_HEIGHT, 13'd3);
    write_reg(blur3_pkg::REG_ZOOM_PERCENT, 13'd0);
    @(negedge clk);
    for (k = 0; k < 9; k++) pixel_q.push_back(k[0] ? 24'h000000 : 24'hFFFFFF);
    wait_drained();

    // zero width acts as one column: every pixel is its own row end
    write_reg(blur3_pkg::REG_IMAGE_WIDTH, 13'd0);
    write_reg(blur3_pkg::REG_IMAGE_HEIGHT, 13'd2);
    write_reg(blur3_pkg::REG_ZOOM_PERCENT, 13'd120);
    send_pixels(2);
    wait_drained();

    // zero height acts as a single row
    write_reg(blur3_pkg::REG_IMAGE_WIDTH, 13'd2);
    write_reg(blur3_pkg::REG_IMAGE_HEIGHT, 13'd0);
    write_reg(blur3_pkg::REG_ZOOM_PERCENT, 13'd171);
    send_pixels(2);
    wait_drained();

    // width saturates, then shrinks below the column count mid row
    write_reg(blur3_pkg::REG_IMAGE_WIDTH, 13'd8191);
    write_reg(blur3_pkg::REG_IMAGE_HEIGHT, 13'd1);
    write_reg(blur3_pkg::REG_ZOOM_PERCENT, 13'd136);
    send_pixels(4);
    wait_drained();
    write_reg(blur3_pkg::REG_IMAGE_WIDTH, 13'd2);
    send_pixels(1);
    wait_drained();

    // height saturates, then shrinks below the current row
    write_reg(blur3_pkg::REG_IMAGE_HEIGHT, 13'd8191);
    write_reg(blur3_pkg::REG_ZOOM_PERCENT, 13'd151);
    send_pixels(6);
    wait_drained();
    write_reg(blur3_pkg::REG_IMAGE_HEIGHT, 13'd2);
    write_reg(blur3_pkg::REG_ZOOM_PERCENT, 13'd1023);
    send_pixels(2);
    wait_drained();

    // output held off while the source keeps offering two whole frames
    write_reg(blur3_pkg::REG_IMAGE_WIDTH, 13'd10);
    write_reg(blur3_pkg::REG_IMAGE_HEIGHT, 13'd5);
    write_reg(blur3_pkg::REG_ZOOM_PERCENT, 13'd128);
    send_pixels(100);
    hold_requests = hold_requests + 1;
    random_pixels = 100;

    while (random_pixels < TARGET_PIXELS) begin
      wait_drained();
      tx_gaps_on   = ($urandom_range(0, 3) != 0);
      rx_stalls_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) < 6) write_reg(blur3_pkg::REG_IMAGE_HEIGHT, pick_height());
      if ($urandom_range(0, 9) < 6) begin
        new_w = pick_width();
        // growing mid frame would read columns never stored
        if (cur_row() != 0 && clamp_width(new_w) > frame_width())
          new_w = 13'($urandom_range(1, frame_width()));
        write_reg(blur3_pkg::REG_IMAGE_WIDTH, new_w);
      end
      if ($urandom_range(0, 9) < 5) write_reg(blur3_pkg::REG_ZOOM_PERCENT, pick_zoom());
      if (frame_width() <= 16 && frame_height() <= 8 && $urandom_range(0, 9) < 8)
        count = frame_pixels_left() + frame_width() * frame_height() * $urandom_range(0, 2);
      else
        count = $urandom_range(1, (frame_width() > 18) ? 40 : 2 * frame_width() + 3);
      // keep the total near the pixel budget
      if (count > TARGET_PIXELS - random_pixels) count = TARGET_PIXELS - random_pixels;
      send_pixels(count);
      random_pixels += count;
    end

    wait_drained();
    $display("run covered %0d pixels, %0d register writes, %0d blurred beats checked",
             pixels_sent, cfg_writes, beats_seen);
    $display("sizes from one pixel up to saturated width and height, all blur strengths");
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
